>>> design/scc_pkg.sv
// shared types and constants for the strongly connected components unit
package scc_pkg;

  localparam int unsigned NodeMax = 64;
  localparam int unsigned IdW = 7;

  localparam logic KindEdge = 1'b0;
  localparam logic KindEnd = 1'b1;

  typedef struct packed {
    logic           kind;
    logic [IdW-1:0] src_node;
    logic [IdW-1:0] dst_node;
  } in_item_t;

  typedef struct packed {
    logic [IdW-1:0] node_id;
    logic [IdW-1:0] component_id;
    logic [IdW-1:0] component_total;
    logic           last;
  } out_item_t;

endpackage

>>> design/scc_mat.sv
// adjacency matrix memory: one row written and one row read per cycle
module scc_mat import scc_pkg::*; #(
  parameter int unsigned MAX_NODES = NodeMax,
  parameter int unsigned AW = $clog2(MAX_NODES)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic [MAX_NODES-1:0] wdata,
  input  logic [AW-1:0]        raddr,
  output logic [MAX_NODES-1:0] rdata
);

  logic [MAX_NODES-1:0] mem [MAX_NODES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/scc_pick.sv
// lowest set bit of a row, found with a registered two-level search
module scc_pick import scc_pkg::*; #(
  parameter int unsigned MAX_NODES = NodeMax,
  parameter int unsigned AW = $clog2(MAX_NODES)
) (
  input  logic                 clk,
  input  logic [MAX_NODES-1:0] vec,
  output logic                 found,
  output logic [AW-1:0]        idx
);

  localparam int unsigned GW = 8;
  localparam int unsigned NG = (MAX_NODES + GW - 1) / GW;
  localparam int unsigned GSW = (NG > 1) ? $clog2(NG) : 1;
  localparam int unsigned BSW = $clog2(GW);

  logic [NG*GW-1:0] padded;
  logic [NG-1:0]    grp_any;
  logic [GW-1:0]    grp_bits [NG];
  logic [NG-1:0]    grp_any_q;
  logic [GW-1:0]    grp_bits_q [NG];
  logic [GSW-1:0]   g_sel;
  logic [BSW-1:0]   b_sel;

  always_comb begin
    padded = '0;
    padded[MAX_NODES-1:0] = vec;
    for (int g = 0; g < NG; g++) begin
      grp_bits[g] = padded[g*GW +: GW];
      grp_any[g] = |grp_bits[g];
    end
  end

  always_ff @(posedge clk) begin
    grp_any_q <= grp_any;
    grp_bits_q <= grp_bits;
  end

  always_comb begin
    g_sel = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (grp_any_q[g]) g_sel = GSW'(g);
    end
    b_sel = '0;
    for (int b = GW - 1; b >= 0; b--) begin
      if (grp_bits_q[g_sel][b]) b_sel = BSW'(b);
    end
    found = |grp_any_q;
    idx = AW'({g_sel, b_sel});
  end

endmodule

>>> design/strongly_connected_components_unit.sv
// top level: kosaraju strongly connected components over a stored graph
//
//  channel  | direction | handshake     | payload
//  in       | input     | valid / ready | in_item_t (kind, src_node, dst_node)
//  out      | output    | valid / ready | out_item_t (node_id, component_id, total, last)
//  cfg      | input     | write enable  | node_count, 7 bits
//
// an edge item reads the rows of both matrices, then sets the edge bits and writes both rows back
// an end item runs two walks; each step reads one matrix row and searches it
// for the lowest eligible neighbor (read, search and decide states); each node costs a step to
// enter and a step to leave in each walk, plus a root check per root
// candidate in the first walk and per finish entry in the second; then n
// results in ascending node order, then a clearing pass over all MAX_NODES matrix rows
// reset is synchronous; the matrices get that same clearing pass after reset
// a stall on the output holds the result and the sequencer waits
module strongly_connected_components_unit import scc_pkg::*; #(
  parameter int unsigned MAX_NODES = NodeMax
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item,
  input  logic      cfg_we,
  input  logic [IdW-1:0] cfg_wdata
);

  localparam int unsigned AW = $clog2(MAX_NODES);
  localparam int unsigned CW = $clog2(MAX_NODES + 1);

  // sequencer states
  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_EDGE_R = 4'd2;
  localparam logic [3:0] S_EDGE_W = 4'd3;
  localparam logic [3:0] S_F_ROOT = 4'd4;
  localparam logic [3:0] S_F_RD   = 4'd5;
  localparam logic [3:0] S_F_SRCH = 4'd6;
  localparam logic [3:0] S_F_DEC  = 4'd7;
  localparam logic [3:0] S_R_ROOT = 4'd8;
  localparam logic [3:0] S_R_RD   = 4'd9;
  localparam logic [3:0] S_R_SRCH = 4'd10;
  localparam logic [3:0] S_R_DEC  = 4'd11;
  localparam logic [3:0] S_EMIT   = 4'd12;
  localparam logic [3:0] S_EMIT_W = 4'd13;
  localparam logic [3:0] S_R_FO   = 4'd14;

  logic [3:0] state;
  logic [IdW-1:0] node_count;

  // effective node count, 1..MAX_NODES
  logic [CW-1:0] n_eff;
  always_comb begin
    if (node_count == '0) n_eff = CW'(1);
    else if (32'(node_count) > MAX_NODES) n_eff = CW'(MAX_NODES);
    else n_eff = CW'(node_count);
  end

  // mask of nodes below the effective count
  logic [MAX_NODES-1:0] live_mask;
  always_comb begin
    for (int i = 0; i < MAX_NODES; i++) live_mask[i] = (32'(i) < 32'(n_eff));
  end

  // matrices
  logic                 fw_we, rv_we;
  logic [AW-1:0]        fw_waddr, rv_waddr, fw_raddr, rv_raddr;
  logic [MAX_NODES-1:0] fw_wdata, rv_wdata, fw_rdata, rv_rdata;

  scc_mat #(.MAX_NODES(MAX_NODES), .AW(AW)) u_fw (
    .clk(clk), .we(fw_we), .waddr(fw_waddr), .wdata(fw_wdata),
    .raddr(fw_raddr), .rdata(fw_rdata)
  );
  scc_mat #(.MAX_NODES(MAX_NODES), .AW(AW)) u_rv (
    .clk(clk), .we(rv_we), .waddr(rv_waddr), .wdata(rv_wdata),
    .raddr(rv_raddr), .rdata(rv_rdata)
  );

  // walk state
  logic [MAX_NODES-1:0] visited1, visited2;
  logic [AW-1:0] stack [MAX_NODES];
  logic [AW-1:0] finish [MAX_NODES];
  logic [IdW-1:0] comp [MAX_NODES];
  logic [CW-1:0] sp, finished, k, root;
  logic [AW-1:0] cur, src_a, dst_a, emit_i;
  logic [IdW-1:0] comp_ctr;
  logic          edge_ok;
  logic [AW-1:0] stack_top, fo_rd;
  logic [IdW-1:0] comp_rd;

  // shared search unit: lowest eligible neighbor in the row just read
  logic [MAX_NODES-1:0] cand;
  logic                 pick_found;
  logic [AW-1:0]        pick_idx;
  logic                 fwd_phase;

  assign fwd_phase = (state == S_F_RD) || (state == S_F_SRCH) || (state == S_F_DEC);
  assign cand = fwd_phase ? (fw_rdata & ~visited1 & live_mask)
                          : (rv_rdata & ~visited2 & live_mask);

  scc_pick #(.MAX_NODES(MAX_NODES), .AW(AW)) u_pick (
    .clk(clk), .vec(cand), .found(pick_found), .idx(pick_idx)
  );

  // stack entry needed on a pop: the parent in the first walk, the next
  // pending node in the second; read during the search cycle
  logic [AW-1:0] stack_ra;
  assign stack_ra = fwd_phase ? (sp[AW-1:0] - AW'(2)) : sp[AW-1:0];

  // registered memory reads of the stack, finish order and labels
  always_ff @(posedge clk) begin
    stack_top <= stack[stack_ra];
    fo_rd <= finish[k[AW-1:0] - AW'(1)];
    comp_rd <= comp[emit_i];
  end

  assign in_ready = (state == S_IDLE);

  // matrix port control
  always_comb begin
    fw_we = 1'b0; rv_we = 1'b0;
    fw_waddr = src_a; rv_waddr = dst_a;
    fw_wdata = fw_rdata; rv_wdata = rv_rdata;
    fw_raddr = cur; rv_raddr = cur;
    case (state)
      S_CLEAR: begin
        fw_we = 1'b1; rv_we = 1'b1;
        fw_waddr = cur; rv_waddr = cur;
        fw_wdata = '0; rv_wdata = '0;
      end
      S_EDGE_R: begin
        fw_raddr = src_a; rv_raddr = dst_a;
      end
      S_EDGE_W: begin
        fw_raddr = src_a; rv_raddr = dst_a;
        fw_we = edge_ok; rv_we = edge_ok;
        fw_wdata = fw_rdata | (MAX_NODES'(1) << dst_a);
        rv_wdata = rv_rdata | (MAX_NODES'(1) << src_a);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cur <= '0;
      node_count <= IdW'(1);
      out_valid <= 1'b0;
      visited1 <= '0;
      visited2 <= '0;
      comp_ctr <= IdW'(1);
      sp <= '0;
      finished <= '0;
    end else begin
      if (cfg_we) node_count <= cfg_wdata;
      // the emit state handles its own handshake
      if (out_valid && out_ready && state != S_EMIT_W) out_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          cur <= cur + AW'(1);
          if (32'(cur) == MAX_NODES - 1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            if (in_item.kind == KindEdge) begin
              edge_ok <= (in_item.src_node != '0) && (32'(in_item.src_node) <= MAX_NODES)
                      && (in_item.dst_node != '0) && (32'(in_item.dst_node) <= MAX_NODES);
              src_a <= AW'(in_item.src_node - IdW'(1));
              dst_a <= AW'(in_item.dst_node - IdW'(1));
              state <= S_EDGE_R;
            end else begin
              root <= '0;
              state <= S_F_ROOT;
            end
          end
        end
        S_EDGE_R: state <= S_EDGE_W;
        S_EDGE_W: state <= S_IDLE;
        // first pass: roots in ascending order
        S_F_ROOT: begin
          if (root == n_eff) begin
            k <= finished;
            state <= S_R_FO;
          end else if (visited1[root[AW-1:0]]) begin
            root <= root + CW'(1);
          end else begin
            visited1[root[AW-1:0]] <= 1'b1;
            stack[0] <= root[AW-1:0];
            sp <= CW'(1);
            cur <= root[AW-1:0];
            root <= root + CW'(1);
            state <= S_F_RD;
          end
        end
        S_F_RD: state <= S_F_SRCH;
        S_F_SRCH: state <= S_F_DEC;
        S_F_DEC: begin
          // visited neighbors are masked, so restarting the scan equals resuming it
          if (pick_found && 32'(sp) < MAX_NODES) begin
            visited1[pick_idx] <= 1'b1;
            stack[sp[AW-1:0]] <= pick_idx;
            sp <= sp + CW'(1);
            cur <= pick_idx;
            state <= S_F_RD;
          end else begin
            finish[finished[AW-1:0]] <= cur;
            finished <= finished + CW'(1);
            sp <= sp - CW'(1);
            if (sp == CW'(1)) begin
              state <= S_F_ROOT;
            end else begin
              cur <= stack_top;
              state <= S_F_RD;
            end
          end
        end
        // second pass: roots in decreasing finish order
        S_R_FO: begin
          if (k == '0) begin
            emit_i <= '0;
            state <= S_EMIT;
          end else begin
            state <= S_R_ROOT;
          end
        end
        S_R_ROOT: begin
          k <= k - CW'(1);
          if (!visited2[fo_rd]) begin
            visited2[fo_rd] <= 1'b1;
            comp[fo_rd] <= comp_ctr;
            stack[0] <= fo_rd;
            sp <= '0;
            cur <= fo_rd;
            state <= S_R_RD;
          end else begin
            state <= S_R_FO;
          end
        end
        S_R_RD: state <= S_R_SRCH;
        S_R_SRCH: state <= S_R_DEC;
        S_R_DEC: begin
          // label every unvisited neighbor of cur, lowest first, one per step
          if (pick_found) begin
            visited2[pick_idx] <= 1'b1;
            comp[pick_idx] <= comp_ctr;
            stack[sp[AW-1:0] + AW'(1)] <= pick_idx;
            sp <= sp + CW'(1);
            state <= S_R_RD;
          end else if (sp == '0) begin
            comp_ctr <= comp_ctr + IdW'(1);
            state <= S_R_FO;
          end else begin
            cur <= stack_top;
            sp <= sp - CW'(1);
            state <= S_R_RD;
          end
        end
        // results in ascending node order
        S_EMIT: state <= S_EMIT_W;
        S_EMIT_W: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_item.node_id <= IdW'(emit_i) + IdW'(1);
            out_item.component_id <= comp_rd;
            out_item.component_total <= comp_ctr - IdW'(1);
            out_item.last <= (32'(emit_i) + 1 == 32'(n_eff));
            if (32'(emit_i) + 1 == 32'(n_eff)) begin
              visited1 <= '0;
              visited2 <= '0;
              comp_ctr <= IdW'(1);
              finished <= '0;
              sp <= '0;
              cur <= '0;
              state <= S_CLEAR;
            end else begin
              emit_i <= emit_i + AW'(1);
              state <= S_EMIT;
            end
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  // no item is taken while a walk or the clearing pass runs
  assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready)
    else $error("input ready outside idle");

  // a stalled result stays offered and unchanged
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_item)))
    else $error("result dropped or changed while stalled");

  // walk depth never exceeds the node limit
  assert property (@(posedge clk) disable iff (rst)
    32'(sp) <= MAX_NODES)
    else $error("walk stack overflow");

endmodule
